/* rtl/pps_pkg.sv */
// Shared codes and types of the preemptive priority scheduler.
package pps_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_ADMIT = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_EXEC,
      ST_FIN
   } state_type;

   // Command broadcast from the sequencer to all slot cells.
   typedef struct packed {
      logic load;
      logic admit;
      logic step;
      logic clear;
   } cmd_type;

endpackage

/* rtl/pps_cell.sv */
// One process slot cell: slot state plus one stage of the selection chain.
module pps_cell #(
   parameter int ID_BITS   = 4,
   parameter int CNT_BITS  = 5,
   parameter int TIME_BITS = 32,
   parameter int SLOT      = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pps_pkg::cmd_type     cmd,
   input  logic [ID_BITS-1:0]   cmd_slot,
   input  logic [7:0]           cmd_prio,
   input  logic [15:0]          cmd_dur,
   input  logic [TIME_BITS-1:0] cmd_time,
   input  logic                 cand_in_valid,
   input  logic [7:0]           cand_in_prio,
   input  logic [ID_BITS-1:0]   cand_in_id,
   output logic                 cand_out_valid,
   output logic [7:0]           cand_out_prio,
   output logic [ID_BITS-1:0]   cand_out_id,
   output logic                 ready,
   output logic [CNT_BITS-1:0]  count,
   output logic [CNT_BITS-1:0]  cursor,
   output logic [TIME_BITS-1:0] arrival,
   output logic [TIME_BITS-1:0] total
);
   import pps_pkg::*;

   logic                 ready_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  cursor_ff;
   logic [7:0]           prio_ff;
   logic [TIME_BITS-1:0] arrival_ff;
   logic [TIME_BITS-1:0] total_ff;
   logic [TIME_BITS-1:0] total_in;
   logic [TIME_BITS:0]   sum;
   logic                 hit;
   logic                 take;
   logic                 cand_valid_ff;
   logic [7:0]           cand_prio_ff;
   logic [ID_BITS-1:0]   cand_id_ff;

   assign hit = (cmd_slot == ID_BITS'(SLOT));
   assign sum = {1'b0, total_ff} + (TIME_BITS+1)'(cmd_dur);
   assign total_in = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   // Take over the candidate only on a strictly better priority: lower ids win ties.
   assign take = ready_ff && (!cand_in_valid || (prio_ff < cand_in_prio));

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         count_ff  <= '0;
         cursor_ff <= '0;
         total_ff  <= '0;
      end else if (hit) begin
         if (cmd.load) begin
            count_ff <= count_ff + CNT_BITS'(1);
            total_ff <= total_in;
         end
         if (cmd.admit) begin
            ready_ff  <= 1'b1;
            cursor_ff <= '0;
         end
         if (cmd.step) cursor_ff <= cursor_ff + CNT_BITS'(1);
         if (cmd.clear) begin
            ready_ff  <= 1'b0;
            count_ff  <= '0;
            cursor_ff <= '0;
            total_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit && cmd.admit) begin
         prio_ff    <= cmd_prio;
         arrival_ff <= cmd_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cand_valid_ff <= 1'b0;
      else       cand_valid_ff <= take || cand_in_valid;
   end

   always_ff @(posedge clock) begin
      cand_prio_ff <= take ? prio_ff : cand_in_prio;
      cand_id_ff   <= take ? ID_BITS'(SLOT) : cand_in_id;
   end

   assign cand_out_valid = cand_valid_ff;
   assign cand_out_prio  = cand_prio_ff;
   assign cand_out_id    = cand_id_ff;
   assign ready          = ready_ff;
   assign count          = count_ff;
   assign cursor         = cursor_ff;
   assign arrival        = arrival_ff;
   assign total          = total_ff;

endmodule

/* rtl/preemptive_priority_scheduler_top.sv */
// Top level of the preemptive priority scheduler: sequencer, cell chain, duration memory.
//
// Usage: drive req_op, req_process_id, req_priority_req and req_duration and raise
// start; the transaction is taken at a rising edge with start high and busy low.
// Every transaction yields exactly one result, shown for one cycle with rsp_valid
// high; the receiver cannot stall and must take it in that cycle.
// For load and admit transactions the result follows on the next cycle
// and busy stays low, so a new transaction may be issued at once.
// A tick with an instruction already running goes straight to the execute step.
// A tick with nothing running first sweeps the selection chain: the best
// (priority, id) candidate moves one cell per cycle through PROCESS_SLOTS cells.
// A fetch step then reads the duration memory if the winner has an instruction
// left, and an execute step follows. A tick that finishes a process adds a finish
// step to form the waiting time.
// Reset clears all slots, the clock, the running instruction and the result strobe;
// no clearing pass is needed, the duration memory is read only after being written.
module preemptive_priority_scheduler_top #(
   parameter int PROCESS_SLOTS            = 16,
   parameter int INSTRUCTIONS_PER_PROCESS = 16,
   parameter int TIME_BITS                = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_process_id,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_duration,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic        rsp_running_valid,
   output logic [3:0]  rsp_running_id,
   output logic        rsp_instruction_done,
   output logic        rsp_finished,
   output logic [3:0]  rsp_finished_id,
   output logic [31:0] rsp_turnaround,
   output logic [31:0] rsp_waiting
);
   import pps_pkg::*;

   localparam int ID_BITS   = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int IDX_BITS  = (INSTRUCTIONS_PER_PROCESS > 1) ?
                              $clog2(INSTRUCTIONS_PER_PROCESS) : 1;
   localparam int CNT_BITS  = $clog2(INSTRUCTIONS_PER_PROCESS + 1);
   localparam int ADDR_BITS = ID_BITS + IDX_BITS;
   localparam int SCAN_BITS = $clog2(PROCESS_SLOTS + 2);

   // Slot cell outputs.
   logic                 cv   [PROCESS_SLOTS+1];
   logic [7:0]           cp   [PROCESS_SLOTS+1];
   logic [ID_BITS-1:0]   ci   [PROCESS_SLOTS+1];
   logic                 s_ready  [PROCESS_SLOTS];
   logic [CNT_BITS-1:0]  s_count  [PROCESS_SLOTS];
   logic [CNT_BITS-1:0]  s_cursor [PROCESS_SLOTS];
   logic [TIME_BITS-1:0] s_arr    [PROCESS_SLOTS];
   logic [TIME_BITS-1:0] s_total  [PROCESS_SLOTS];

   state_type            state_ff, state_in;
   logic [SCAN_BITS-1:0] scan_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 run_ff;
   logic                 start_ff;
   logic [ID_BITS-1:0]   run_id_ff;
   logic [15:0]          left_ff;
   logic [15:0]          mem_q_ff;
   logic [15:0]          dur_mem [0:(1<<ADDR_BITS)-1];
   logic [TIME_BITS-1:0] ta_ff, tw_ff;

   cmd_type              cmd;
   logic [ID_BITS-1:0]   cmd_slot;
   logic                 accept, pid_ok, load_ok, admit_ok;
   logic [ID_BITS-1:0]   pid_slot;
   logic [15:0]          dur_fix;
   logic [15:0]          left_src;
   logic                 done, fin;
   logic [TIME_BITS-1:0] time_next;
   logic [TIME_BITS-1:0] ta, wt;
   logic [63:0]          ta64, wt64;
   logic                 win_ok;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign pid_slot = ID_BITS'(req_process_id);
   assign pid_ok   = (32'(req_process_id) < 32'(PROCESS_SLOTS));
   assign load_ok  = pid_ok && !s_ready[pid_slot] &&
                     (s_count[pid_slot] < CNT_BITS'(INSTRUCTIONS_PER_PROCESS));
   assign admit_ok = pid_ok && !s_ready[pid_slot] && (s_count[pid_slot] != '0);
   // A zero duration counts as one time unit.
   assign dur_fix  = (req_duration == 16'd0) ? 16'd1 : req_duration;

   // Execute-step arithmetic.
   assign left_src  = start_ff ? mem_q_ff : left_ff;
   assign done      = run_ff && (left_src == 16'd1);
   assign fin       = done && ((s_cursor[run_id_ff] + CNT_BITS'(1)) >= s_count[run_id_ff]);
   assign time_next = (time_ff == {TIME_BITS{1'b1}}) ? time_ff : time_ff + TIME_BITS'(1);
   assign ta        = (time_next >= s_arr[run_id_ff]) ? time_next - s_arr[run_id_ff] : '0;
   assign wt        = (ta_ff >= tw_ff) ? ta_ff - tw_ff : '0;
   assign ta64      = 64'(ta_ff);
   assign wt64      = 64'(wt);
   // The winner that leaves the chain end must still have an instruction left.
   assign win_ok    = cv[PROCESS_SLOTS] &&
                      (s_cursor[ci[PROCESS_SLOTS]] < s_count[ci[PROCESS_SLOTS]]);

   // Command broadcast to the cells.
   always_comb begin
      cmd      = '0;
      cmd_slot = pid_slot;
      if (accept && (req_op == OP_LOAD))  cmd.load  = load_ok;
      if (accept && (req_op == OP_ADMIT)) cmd.admit = admit_ok;
      if (state_ff == ST_EXEC) begin
         cmd_slot  = run_id_ff;
         cmd.step  = done && !fin;
         cmd.clear = fin;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_TICK)) state_in = run_ff ? ST_EXEC : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff == SCAN_BITS'(PROCESS_SLOTS)) state_in = win_ok ? ST_FETCH : ST_EXEC;
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC:  state_in = fin ? ST_FIN : ST_IDLE;
         ST_FIN:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Control registers: scan counter, clock, running instruction.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         time_ff   <= '0;
         run_ff    <= 1'b0;
         start_ff  <= 1'b0;
         run_id_ff <= '0;
         left_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: scan_ff <= '0;
            ST_SCAN: begin
               scan_ff <= scan_ff + SCAN_BITS'(1);
               if ((scan_ff == SCAN_BITS'(PROCESS_SLOTS)) && win_ok) begin
                  run_id_ff <= ci[PROCESS_SLOTS];
               end
            end
            ST_FETCH: begin
               run_ff   <= 1'b1;
               start_ff <= 1'b1;
            end
            ST_EXEC: begin
               time_ff  <= time_next;
               start_ff <= 1'b0;
               if (run_ff) begin
                  left_ff <= left_src - 16'd1;
                  if (done) run_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Duration memory: write on an accepted load, read the next instruction on fetch.
   always_ff @(posedge clock) begin
      if (cmd.load) dur_mem[{pid_slot, s_count[pid_slot][IDX_BITS-1:0]}] <= dur_fix;
      if (state_ff == ST_FETCH) begin
         mem_q_ff <= dur_mem[{run_id_ff, s_cursor[run_id_ff][IDX_BITS-1:0]}];
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= (accept && (req_op != OP_TICK)) ||
                              ((state_ff == ST_EXEC) && !fin) || (state_ff == ST_FIN);
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept && (req_op != OP_TICK)) begin
         rsp_accepted         <= ((req_op == OP_LOAD) && load_ok) ||
                                 ((req_op == OP_ADMIT) && admit_ok);
         rsp_running_valid    <= 1'b0;
         rsp_running_id       <= '0;
         rsp_instruction_done <= 1'b0;
         rsp_finished         <= 1'b0;
         rsp_finished_id      <= '0;
         rsp_turnaround       <= '0;
         rsp_waiting          <= '0;
      end
      if (state_ff == ST_EXEC) begin
         rsp_accepted         <= 1'b1;
         rsp_running_valid    <= run_ff;
         rsp_running_id       <= run_ff ? 4'(run_id_ff) : 4'd0;
         rsp_instruction_done <= done;
         rsp_finished         <= fin;
         rsp_finished_id      <= fin ? 4'(run_id_ff) : 4'd0;
         rsp_turnaround       <= '0;
         rsp_waiting          <= '0;
         ta_ff                <= ta;
         tw_ff                <= s_total[run_id_ff];
      end
      if (state_ff == ST_FIN) begin
         rsp_turnaround <= (ta64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ta64[31:0];
         rsp_waiting    <= (wt64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wt64[31:0];
      end
   end

   // Cell chain: the candidate enters empty at the head and leaves at the tail.
   assign cv[0] = 1'b0;
   assign cp[0] = 8'd0;
   assign ci[0] = '0;

   for (genvar g = 0; g < PROCESS_SLOTS; g++) begin : g_cell
      pps_cell #(
         .ID_BITS  (ID_BITS),
         .CNT_BITS (CNT_BITS),
         .TIME_BITS(TIME_BITS),
         .SLOT     (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .cmd_slot      (cmd_slot),
         .cmd_prio      (req_priority_req),
         .cmd_dur       (dur_fix),
         .cmd_time      (time_ff),
         .cand_in_valid (cv[g]),
         .cand_in_prio  (cp[g]),
         .cand_in_id    (ci[g]),
         .cand_out_valid(cv[g+1]),
         .cand_out_prio (cp[g+1]),
         .cand_out_id   (ci[g+1]),
         .ready         (s_ready[g]),
         .count         (s_count[g]),
         .cursor        (s_cursor[g]),
         .arrival       (s_arr[g]),
         .total         (s_total[g])
      );
   end

   // Finishing is only reached from an execute step.
   a_fin_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> ($past(state_ff) == ST_EXEC))
      else $error("finish step not preceded by execute step");

   a_fin_has_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_instruction_done && rsp_running_valid))
      else $error("finish reported without completed instruction");

   a_run_left: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !start_ff && (state_ff == ST_IDLE)) |-> (left_ff != 16'd0))
      else $error("running instruction has no time left");

   a_no_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> !rsp_valid || (state_ff != ST_FETCH))
      else $error("result strobe during fetch");

endmodule

/* verif/preemptive_priority_scheduler_checker.sv */
// Checker: predicts scheduler results from accepted transactions and compares them.
module preemptive_priority_scheduler_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_process_id,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_duration,
   input  logic        rsp_valid,
   input  logic        rsp_accepted,
   input  logic        rsp_running_valid,
   input  logic [3:0]  rsp_running_id,
   input  logic        rsp_instruction_done,
   input  logic        rsp_finished,
   input  logic [3:0]  rsp_finished_id,
   input  logic [31:0] rsp_turnaround,
   input  logic [31:0] rsp_waiting,
   output int          error_count,
   output int          pending_count,
   output int          finish_count
);
   import pps_pkg::*;

   typedef struct packed {
      logic        accepted;
      logic        running_valid;
      logic [3:0]  running_id;
      logic        instruction_done;
      logic        finished;
      logic [3:0]  finished_id;
      logic [31:0] turnaround;
      logic [31:0] waiting;
   } sched_result_type;

   localparam int SLOTS = 16;
   localparam int DEPTH = 16;
   localparam logic [31:0] TIME_TOP = 32'hFFFF_FFFF;

   logic [7:0]  slot_prio  [SLOTS];
   logic        slot_ready [SLOTS];
   int          slot_count [SLOTS];
   int          slot_cursor[SLOTS];
   logic [31:0] slot_arrive[SLOTS];
   logic [32:0] slot_work  [SLOTS];
   logic [15:0] slot_dur   [SLOTS][DEPTH];
   logic [31:0] now_time;
   logic        exec_on;
   int          exec_id;
   int          exec_left;

   sched_result_type expected_results[$];

   function automatic sched_result_type predict_result(logic [1:0] op, int pid,
                                                       logic [7:0] prio, logic [15:0] dur);
      sched_result_type r;
      int best;
      logic [32:0] w;
      logic [31:0] ta, wt;
      r = '0;
      best = -1;
      if (dur == 0) dur = 16'd1;
      if (op == OP_LOAD) begin
         if (!slot_ready[pid] && slot_count[pid] < DEPTH) begin
            slot_dur[pid][slot_count[pid]] = dur;
            slot_count[pid]++;
            w = slot_work[pid] + dur;
            slot_work[pid] = (w > TIME_TOP) ? {1'b0, TIME_TOP} : w;
            r.accepted = 1'b1;
         end
      end else if (op == OP_ADMIT) begin
         if (!slot_ready[pid] && slot_count[pid] > 0) begin
            slot_ready[pid]  = 1'b1;
            slot_prio[pid]   = prio;
            slot_arrive[pid] = now_time;
            slot_cursor[pid] = 0;
            r.accepted = 1'b1;
         end
      end else if (op == OP_TICK) begin
         r.accepted = 1'b1;
         if (!exec_on) begin
            for (int s = 0; s < SLOTS; s++)
               if (slot_ready[s] && (best < 0 || slot_prio[s] < slot_prio[best])) best = s;
            if (best >= 0 && slot_cursor[best] < slot_count[best]) begin
               exec_on   = 1'b1;
               exec_id   = best;
               exec_left = slot_dur[best][slot_cursor[best]];
               if (exec_left == 0) exec_left = 1;
            end
         end
         if (now_time != TIME_TOP) now_time++;
         if (exec_on) begin
            r.running_valid = 1'b1;
            r.running_id    = exec_id[3:0];
            exec_left--;
            if (exec_left == 0) begin
               exec_on = 1'b0;
               r.instruction_done = 1'b1;
               slot_cursor[exec_id]++;
               if (slot_cursor[exec_id] >= slot_count[exec_id]) begin
                  ta = (now_time >= slot_arrive[exec_id]) ? now_time - slot_arrive[exec_id] : 0;
                  wt = ({1'b0, ta} >= slot_work[exec_id]) ? ta - slot_work[exec_id][31:0] : 0;
                  r.finished    = 1'b1;
                  r.finished_id = exec_id[3:0];
                  r.turnaround  = ta;
                  r.waiting     = wt;
                  slot_ready[exec_id]  = 1'b0;
                  slot_count[exec_id]  = 0;
                  slot_cursor[exec_id] = 0;
                  slot_work[exec_id]   = '0;
               end
            end
         end
      end
      return r;
   endfunction

   sched_result_type seen, want;

   always_comb begin
      seen.accepted         = rsp_accepted;
      seen.running_valid    = rsp_running_valid;
      seen.running_id       = rsp_running_id;
      seen.instruction_done = rsp_instruction_done;
      seen.finished         = rsp_finished;
      seen.finished_id      = rsp_finished_id;
      seen.turnaround       = rsp_turnaround;
      seen.waiting          = rsp_waiting;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_ready[s] = 0; slot_count[s] = 0; slot_cursor[s] = 0;
            slot_work[s] = '0; slot_prio[s] = '0; slot_arrive[s] = '0;
         end
         now_time = '0; exec_on = 0; exec_id = 0; exec_left = 0;
         expected_results.delete();
         error_count  <= 0;
         finish_count <= 0;
      end else begin
         // Compare first: a result never shows in the cycle its transaction is taken.
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, seen);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  $display("%0t: result mismatch, expected %p, actual %p", $time, want, seen);
                  error_count <= error_count + 1;
               end
               if (want.finished) finish_count <= finish_count + 1;
            end
         end
         if (start && !busy)
            expected_results = {expected_results,
                                predict_result(req_op, int'(req_process_id),
                                               req_priority_req, req_duration)};
      end
      pending_count <= expected_results.size();
   end

endmodule

/* verif/preemptive_priority_scheduler_top_tb.sv */
// Testbench top: clock, reset, stimulus and verdict for the priority scheduler.
module preemptive_priority_scheduler_top_tb;
   import pps_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_op = OP_TICK;
   logic [3:0]  req_process_id = 0;
   logic [7:0]  req_priority_req = 0;
   logic [15:0] req_duration = 0;
   logic        rsp_valid, rsp_accepted, rsp_running_valid, rsp_instruction_done;
   logic        rsp_finished;
   logic [3:0]  rsp_running_id, rsp_finished_id;
   logic [31:0] rsp_turnaround, rsp_waiting;
   int          error_count, pending_count, finish_count;
   int          cycle_count = 0;
   int          sent_count = 0;

   localparam int CYCLE_LIMIT = 2_000_000;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   preemptive_priority_scheduler_top dut (.*);
   preemptive_priority_scheduler_checker checker_inst (.*);

   // Watchdog: bound the run far above the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("preemptive_priority_scheduler_top_tb: errors");
         $finish;
      end
   end

   // Issue one transaction: hold the request until taken, then lower start
   // only when the sender is going to idle.
   task automatic issue(logic [1:0] op, logic [3:0] pid, logic [7:0] prio,
                        logic [15:0] dur, int gap);
      start            <= 1'b1;
      req_op           <= op;
      req_process_id   <= pid;
      req_priority_req <= prio;
      req_duration     <= dur;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      if (gap > 0) begin
         start <= 1'b0;
         req_op <= 2'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Draw a sender gap; some stretches run back to back.
   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   // Drain: hold off until every expected result has come.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // Build one well-formed process: one or more loads, then an admit.
   task automatic make_process(logic [3:0] pid, int n, bit burst, bit long_jobs);
      for (int i = 0; i < n; i++)
         issue(OP_LOAD, pid, 8'($urandom),
               long_jobs ? 16'($urandom) : 16'($urandom_range(0, 4)), draw_gap(burst));
      issue(OP_ADMIT, pid, 8'($urandom), 16'($urandom), draw_gap(burst));
   endtask

   initial begin
      bit burst;
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: refusals, extreme fields, zero duration, ties, full list.
      issue(OP_ADMIT, 4'd3, 8'd5, 16'd0, 0);          // admit of an empty slot
      issue(OP_TICK, 4'd0, 8'd0, 16'd0, 0);           // idle tick
      issue(OP_SPARE, 4'hF, 8'hFF, 16'hFFFF, 0);      // unused op code
      for (int i = 0; i < 17; i++)                    // fill list then overflow it
         issue(OP_LOAD, 4'hF, 8'd0, (i == 0) ? 16'd0 : 16'd1, 0);
      issue(OP_LOAD, 4'd0, 8'hFF, 16'd2, 0);
      issue(OP_ADMIT, 4'd0, 8'd7, 16'd0, 0);
      issue(OP_ADMIT, 4'd0, 8'd7, 16'd0, 0);          // repeated admit
      issue(OP_LOAD, 4'd0, 8'd0, 16'd3, 0);           // load after admit
      issue(OP_ADMIT, 4'hF, 8'd7, 16'd0, 0);          // tie on priority, lower id wins
      repeat (22) issue(OP_TICK, 4'd0, 8'd0, 16'd0, 0);
      drain();

      // Random: mostly ticks, with well-formed processes and noise mixed in.
      while (sent_count < 1200) begin
         burst = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 9);
         if (pick < 3)
            make_process(4'($urandom), $urandom_range(1, 4), burst,
                         $urandom_range(0, 40) == 0);
         else if (pick < 8)
            repeat ($urandom_range(1, 8)) issue(OP_TICK, 4'($urandom), 8'($urandom),
                                                16'($urandom), draw_gap(burst));
         else
            issue(2'($urandom), 4'($urandom), 8'($urandom), 16'($urandom),
                  draw_gap(burst));
         if ($urandom_range(0, 150) == 0) drain();
      end
      drain();

      $display("Sent %0d transactions; %0d processes ran to completion.",
               sent_count, finish_count);
      if (error_count == 0)
         $display("preemptive_priority_scheduler_top_tb: clean");
      else
         $display("preemptive_priority_scheduler_top_tb: errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/preemptive_priority_scheduler_top.sv
verif/preemptive_priority_scheduler_checker.sv
verif/preemptive_priority_scheduler_top_tb.sv
